/* src/gf2d_pkg.sv */
package gf2d_pkg;

  // Softening register reset value, unsigned Q16.16.
  localparam logic [31:0] SOFT_RESET = 32'd655;

  // Pair term magnitude cap is 2^TERM_CAP_BIT.
  localparam int TERM_CAP_BIT = 50;

  // Pair unit sequencer states.
  typedef enum logic [3:0] {
    P_IDLE,
    P_DIFF,
    P_SQX,
    P_SQY,
    P_PREP,
    P_NORM,
    P_SQRT,
    P_DIV,
    P_U2,
    P_C,
    P_PROD,
    P_LO,
    P_HI,
    P_SCALE,
    P_DONE
  } pair_state_e;

  // Top level sequencer states.
  typedef enum logic [2:0] {
    T_IDLE,
    T_RDI,
    T_LATI,
    T_RDJ,
    T_GO,
    T_WAIT,
    T_EMIT
  } top_state_e;

  // Status and result of one pair evaluation.
  typedef struct packed {
    logic               done;
    logic signed [63:0] tx;
    logic signed [63:0] ty;
  } gf2d_term_t;

endpackage

/* src/gf2d_ram.sv */
module gf2d_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/gf2d_pair.sv */
module gf2d_pair import gf2d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] xi_i,
  input  logic [31:0] yi_i,
  input  logic [31:0] xj_i,
  input  logic [31:0] yj_i,
  input  logic [31:0] mj_i,
  input  logic [31:0] eps_i,
  output gf2d_term_t  term_o
);

  pair_state_e state_q, state_d;

  logic [32:0]         adx_q, ady_q;
  logic                xpos_q, ypos_q;
  logic [31:0]         mj_q;
  logic [65:0]         q_q;
  logic [63:0]         v_q;
  logic [4:0]          lh_q;
  logic                k_q;
  logic [63:0]         res_q, bit_q;
  logic [4:0]          it_q;
  logic [32:0]         rem_q;
  logic [31:0]         u_q, c_q;
  logic [63:0]         pp_q;
  logic [95:0]         full_q;
  logic                ax_q;
  logic signed [63:0]  tx_q, ty_q;

  logic signed [32:0]  dx, dy;
  logic [32:0]         mul_a, mul_b;
  logic [65:0]         mul_p;
  logic [63:0]         rb_sum;
  logic                sq_ge;
  logic [32:0]         div_r2;
  logic                div_ge;
  logic [7:0]          shamt;
  logic [103:0]        sh_v;
  logic                over;
  logic [50:0]         mag;
  logic signed [63:0]  term;

  // Signed differences of the incoming pair.
  assign dx = $signed({xi_i[31], xi_i}) - $signed({xj_i[31], xj_i});
  assign dy = $signed({yi_i[31], yi_i}) - $signed({yj_i[31], yj_i});

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      P_SQX:   begin mul_a = adx_q; mul_b = adx_q; end
      P_SQY:   begin mul_a = ady_q; mul_b = ady_q; end
      P_U2:    begin mul_a = {1'b0, u_q}; mul_b = {1'b0, u_q}; end
      P_C:     begin mul_a = {1'b0, c_q}; mul_b = {1'b0, u_q}; end
      P_PROD:  begin mul_a = {1'b0, mj_q}; mul_b = ax_q ? ady_q : adx_q; end
      P_LO:    begin mul_a = {1'b0, pp_q[31:0]}; mul_b = {1'b0, c_q}; end
      P_HI:    begin mul_a = {1'b0, pp_q[63:32]}; mul_b = {1'b0, c_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Square root step and division step.
  assign rb_sum = res_q + bit_q;
  assign sq_ge  = v_q >= rb_sum;
  assign div_r2 = {rem_q[31:0], 1'b1};
  assign div_ge = div_r2 >= {1'b0, res_q[31:0]};

  // Final scaling: shift by 85 - 3*lh + 3*k, offset by 8 so it is never negative.
  assign shamt = 8'd93 + (k_q ? 8'd3 : 8'd0) - 8'({lh_q, 1'b0}) - 8'(lh_q);
  assign sh_v  = {full_q, 8'b0} >> shamt;
  assign over  = (|sh_v[103:51]) || (sh_v[50] && (|sh_v[49:0]));
  assign mag   = over ? (51'd1 << TERM_CAP_BIT) : sh_v[50:0];
  assign term  = (ax_q ? ypos_q : xpos_q) ? -$signed({13'b0, mag}) : $signed({13'b0, mag});

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      P_IDLE:  if (start_i) state_d = P_DIFF;
      P_DIFF:  state_d = (adx_q == '0 && ady_q == '0) ? P_DONE : P_SQX;
      P_SQX:   state_d = P_SQY;
      P_SQY:   state_d = P_PREP;
      P_PREP:  state_d = P_NORM;
      P_NORM:  if (v_q[63:62] != 2'b00) state_d = P_SQRT;
      P_SQRT:  if (it_q == 5'd31) state_d = P_DIV;
      P_DIV:   if (it_q == 5'd31) state_d = P_U2;
      P_U2:    state_d = P_C;
      P_C:     state_d = P_PROD;
      P_PROD:  state_d = P_LO;
      P_LO:    state_d = P_HI;
      P_HI:    state_d = P_SCALE;
      P_SCALE: state_d = ax_q ? P_DONE : P_PROD;
      P_DONE:  state_d = P_IDLE;
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers, updated by the step in progress.
  always_ff @(posedge clk_i) begin
    case (state_q)
      P_IDLE: begin
        adx_q  <= dx[32] ? 33'(-dx) : 33'(dx);
        ady_q  <= dy[32] ? 33'(-dy) : 33'(dy);
        xpos_q <= !dx[32] && (dx != '0);
        ypos_q <= !dy[32] && (dy != '0);
        mj_q   <= mj_i;
        ax_q   <= 1'b0;
      end
      P_DIFF: begin
        tx_q <= '0;
        ty_q <= '0;
      end
      P_SQX: q_q <= mul_p;
      P_SQY: q_q <= q_q + mul_p + {18'b0, eps_i, 16'b0};
      P_PREP: begin
        lh_q <= '0;
        if (q_q[65:64] != 2'b00) begin
          v_q <= q_q[65:2];
          k_q <= 1'b1;
        end else begin
          v_q <= q_q[63:0];
          k_q <= 1'b0;
        end
      end
      P_NORM: begin
        if (v_q[63:62] == 2'b00) begin
          v_q  <= v_q << 2;
          lh_q <= lh_q + 5'd1;
        end else begin
          res_q <= '0;
          bit_q <= 64'd1 << 62;
          it_q  <= '0;
        end
      end
      P_SQRT: begin
        if (sq_ge) begin
          v_q   <= v_q - rb_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        it_q  <= it_q + 5'd1;
        rem_q <= 33'h0_7FFF_FFFF;
      end
      P_DIV: begin
        rem_q <= div_ge ? (div_r2 - {1'b0, res_q[31:0]}) : div_r2;
        u_q   <= {u_q[30:0], div_ge};
        it_q  <= it_q + 5'd1;
      end
      P_U2:   c_q    <= mul_p[63:32];
      P_C:    c_q    <= mul_p[63:32];
      P_PROD: pp_q   <= mul_p[63:0];
      P_LO:   full_q <= {32'b0, mul_p[63:0]};
      P_HI:   full_q <= full_q + {mul_p[63:0], 32'b0};
      P_SCALE: begin
        if (ax_q) begin
          ty_q <= term;
        end else begin
          tx_q <= term;
        end
        ax_q <= ~ax_q;
      end
      default: begin
      end
    endcase
  end

  // Result of the pair, valid while done is high.
  always_comb begin
    term_o.done = (state_q == P_DONE);
    term_o.tx   = tx_q;
    term_o.ty   = ty_q;
  end

endmodule

/* src/gravity_force_2d_direct_top.sv */
// Channel   Direction  Handshake                    Payload
// item in   input      start_i high, busy_o low     pos_x_i, pos_y_i, mass_i, last_body_i
// result    output     result_strobe_o, one cycle   accel_x_o, accel_y_o, body_index_o,
//                                                   clipped_o, last_result_o
// config    input      cfg_valid_i, cfg_ready_o     cfg_softening_sq_i
//
// A body that does not end the set is written to the body stores while they have room.
// The item marked last starts n*(n-1) pair evaluations in the one shared pair unit; each
// normalizes by 2-bit shifts, then runs the 32-step square root and 32-step divide loops
// and the product and scale steps for each axis; a coincident pair goes straight to done.
// Reset clears the sequencers and the body count; the body stores need no clearing.
// Results cannot be stalled; while busy_o is high, items and configuration writes wait.
module gravity_force_2d_direct_top import gf2d_pkg::*; #(
  parameter int MAX_BODIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [31:0]        mass_i,
  input  logic               last_body_i,
  output logic               result_strobe_o,
  output logic signed [47:0] accel_x_o,
  output logic signed [47:0] accel_y_o,
  output logic [5:0]         body_index_o,
  output logic               clipped_o,
  output logic               last_result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_softening_sq_i
);

  localparam int IW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  top_state_e state_q, state_d;

  logic [31:0]        soft_q;
  logic [CW-1:0]      count_q, n_q;
  logic [IW-1:0]      i_q, j_q;
  logic [31:0]        xi_q, yi_q;
  logic signed [63:0] sum_x_q, sum_y_q;
  logic               strobe_q;
  logic signed [47:0] acc_x_q, acc_y_q;
  logic [5:0]         idx_q;
  logic               clip_q, lastr_q;

  logic               accept, store_en, i_last, j_last;
  logic [IW-1:0]      raddr;
  logic [31:0]        rd_x, rd_y, rd_m;
  gf2d_term_t         term;
  logic               hi_x, lo_x, hi_y, lo_y;

  assign busy_o      = (state_q != T_IDLE);
  assign accept      = start_i && !busy_o;
  assign store_en    = accept && (count_q < CW'(MAX_BODIES));
  assign i_last      = (CW'(i_q) + CW'(1)) == n_q;
  assign j_last      = (CW'(j_q) + CW'(1)) == n_q;
  assign raddr       = (state_q == T_RDI) ? i_q : j_q;
  // The softening value must hold still while a set is being computed.
  assign cfg_ready_o = !busy_o;

  // Body stores.
  gf2d_ram #(.Width(32), .Depth(MAX_BODIES)) u_x_ram (
    .clk_i, .we_i(store_en), .waddr_i(count_q[IW-1:0]), .wdata_i(pos_x_i),
    .raddr_i(raddr), .rdata_o(rd_x)
  );
  gf2d_ram #(.Width(32), .Depth(MAX_BODIES)) u_y_ram (
    .clk_i, .we_i(store_en), .waddr_i(count_q[IW-1:0]), .wdata_i(pos_y_i),
    .raddr_i(raddr), .rdata_o(rd_y)
  );
  gf2d_ram #(.Width(32), .Depth(MAX_BODIES)) u_m_ram (
    .clk_i, .we_i(store_en), .waddr_i(count_q[IW-1:0]), .wdata_i(mass_i),
    .raddr_i(raddr), .rdata_o(rd_m)
  );

  // Shared pair unit.
  gf2d_pair u_pair (
    .clk_i, .rst_ni, .start_i(state_q == T_GO),
    .xi_i(xi_q), .yi_i(yi_q), .xj_i(rd_x), .yj_i(rd_y), .mj_i(rd_m),
    .eps_i(soft_q), .term_o(term)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (accept && last_body_i) state_d = T_RDI;
      T_RDI:  state_d = T_LATI;
      T_LATI: state_d = T_RDJ;
      T_RDJ: begin
        if (j_q != i_q) begin
          state_d = T_GO;
        end else if (j_last) begin
          state_d = T_EMIT;
        end
      end
      T_GO:   state_d = T_WAIT;
      T_WAIT: if (term.done) state_d = j_last ? T_EMIT : T_RDJ;
      T_EMIT: state_d = i_last ? T_IDLE : T_RDI;
      default: state_d = T_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      soft_q   <= SOFT_RESET;
      count_q  <= '0;
      n_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == T_EMIT);
      if (cfg_valid_i && cfg_ready_o) begin
        soft_q <= cfg_softening_sq_i;
      end
      if (accept) begin
        if (last_body_i) begin
          count_q <= '0;
          n_q     <= count_q + (store_en ? CW'(1) : CW'(0));
          i_q     <= '0;
        end else if (store_en) begin
          count_q <= count_q + CW'(1);
        end
      end
      if (state_q == T_LATI) begin
        j_q <= '0;
      end
      if ((state_q == T_RDJ && j_q == i_q && !j_last) ||
          (state_q == T_WAIT && term.done && !j_last)) begin
        j_q <= j_q + IW'(1);
      end
      if (state_q == T_EMIT) begin
        i_q <= i_q + IW'(1);
      end
    end
  end

  // Saturation of the 64-bit sums to 48 bits.
  assign hi_x = !sum_x_q[63] && (|sum_x_q[62:47]);
  assign lo_x = sum_x_q[63] && !(&sum_x_q[62:47]);
  assign hi_y = !sum_y_q[63] && (|sum_y_q[62:47]);
  assign lo_y = sum_y_q[63] && !(&sum_y_q[62:47]);

  // Body i operands, accumulation and the result register.
  always_ff @(posedge clk_i) begin
    if (state_q == T_LATI) begin
      xi_q    <= rd_x;
      yi_q    <= rd_y;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end
    if (state_q == T_WAIT && term.done) begin
      sum_x_q <= sum_x_q + term.tx;
      sum_y_q <= sum_y_q + term.ty;
    end
    if (state_q == T_EMIT) begin
      acc_x_q <= hi_x ? {1'b0, {47{1'b1}}} : (lo_x ? {1'b1, 47'b0} : sum_x_q[47:0]);
      acc_y_q <= hi_y ? {1'b0, {47{1'b1}}} : (lo_y ? {1'b1, 47'b0} : sum_y_q[47:0]);
      idx_q   <= 6'(i_q);
      clip_q  <= hi_x || lo_x || hi_y || lo_y;
      lastr_q <= i_last;
    end
  end

  assign result_strobe_o = strobe_q;
  assign accel_x_o       = acc_x_q;
  assign accel_y_o       = acc_y_q;
  assign body_index_o    = idx_q;
  assign clipped_o       = clip_q;
  assign last_result_o   = lastr_q;

  // A result appears only right after the emit step.
  a_strobe_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == T_EMIT))
    else $error("result strobe without emit step");

  // The pair unit finishes only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term.done |-> (state_q == T_WAIT))
    else $error("pair result outside wait step");

  // The store never counts past its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BODIES))
    else $error("body count beyond capacity");

  // The final result of a set leaves the block idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_result_o) |-> (state_q == T_IDLE))
    else $error("last result while still busy");

endmodule
